// ===== sv/fdsd_pkg.sv =====
// Shared types and constants for the flux data separator DPLL.
// Holds the channel payload structs, register indexes and the
// controller-to-datapath command and status structs. No dependencies.
package fdsd_pkg;

  // Default parameter values.
  localparam int LOCK_ONES_DEF = 256;
  localparam int MAX_CELLS_DEF = 64;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register reset values.
  localparam logic        LOOP_MODE_RST      = 1'b0;
  localparam logic [13:0] CLOCK_CENTRE_RST   = 14'd4000;
  localparam logic [13:0] CLOCK_FLOOR_RST    = 14'd3400;
  localparam logic [13:0] CLOCK_CEILING_RST  = 14'd4600;
  localparam logic [6:0]  ADJUST_PERCENT_RST = 7'd15;
  localparam logic [15:0] LOOP_GAINS_RST     = 16'd39961;
  localparam logic [15:0] NOISE_FLOOR_RST    = 16'd100;
  localparam logic [7:0]  ZERO_RUN_LIMIT_RST = 8'd32;

  // Divide by 100 as multiply by ceil(2^27/100) and shift by 27.
  // Exact for magnitudes below about 1.8 million.
  localparam int          RECIP_SHIFT = 27;
  localparam logic [20:0] RECIP_100   = 21'd1342178;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOOP_MODE      = 3'd0,
    REG_CLOCK_CENTRE   = 3'd1,
    REG_CLOCK_FLOOR    = 3'd2,
    REG_CLOCK_CEILING  = 3'd3,
    REG_ADJUST_PERCENT = 3'd4,
    REG_LOOP_GAINS     = 3'd5,
    REG_NOISE_FLOOR    = 3'd6,
    REG_ZERO_RUN_LIMIT = 3'd7
  } cfg_reg_t;

  // Input opcodes.
  localparam logic OPC_FLUX  = 1'b0;
  localparam logic OPC_INDEX = 1'b1;

  // Input beat payload.
  typedef struct packed {
    logic        opcode;
    logic [15:0] flux_interval;
  } in_t;

  // Result beat payload.
  typedef struct packed {
    logic cell_bit;
    logic last_cell;
    logic locked;
    logic overrun;
  } out_t;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    DP_NOP,
    DP_INDEX,
    DP_ADD,
    DP_CELL,
    DP_MUL,
    DP_RECIP,
    DP_INTEG,
    DP_SUM_PI,
    DP_APPLY,
    DP_PHASE,
    DP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   emit;     // with DP_CELL: send the pending cell as a non-final beat
    logic   overrun;  // with DP_FINISH: cell limit reached, clear the phase
  } dp_cmd_t;

  typedef struct packed {
    logic more;       // phase at least half a cell period
    logic zero_cell;  // phase at least one and a half cell periods
    logic out_free;   // output register can take a beat this cycle
    logic pi_mode;    // proportional-integral loop selected
    logic is_index;   // input beat is an index pulse
    logic is_short;   // input interval below the noise floor
  } dp_status_t;

endpackage

// ===== sv/fdsd_datapath.sv =====
// Datapath of the flux data separator: configuration registers, loop state,
// the multiplier steps and the output register.
// Depends on fdsd_pkg; driven by commands from fdsd_ctrl.
module fdsd_datapath #(
  parameter int LockOnes = fdsd_pkg::LOCK_ONES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [fdsd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fdsd_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  fdsd_pkg::in_t                     in_data,
  input  fdsd_pkg::dp_cmd_t                 cmd,
  output fdsd_pkg::dp_status_t              status,
  output logic                              out_valid,
  input  logic                              out_ready,
  output fdsd_pkg::out_t                    out_data
);

  // Configuration registers.
  logic        loop_mode_r;
  logic [13:0] clock_centre_r;
  logic [13:0] clock_floor_r;
  logic [13:0] clock_ceiling_r;
  logic [6:0]  adjust_percent_r;
  logic [15:0] loop_gains_r;
  logic [15:0] noise_floor_r;
  logic [7:0]  zero_run_limit_r;

  // Loop state.
  logic [13:0]        period_r,    period_nxt;
  logic signed [17:0] phase_r,     phase_nxt;
  logic [7:0]         zero_run_r,  zero_run_nxt;
  logic [8:0]         ones_r,      ones_nxt;
  logic               lock_r,      lock_nxt;
  logic signed [22:0] integ_r,     integ_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Working registers.
  logic signed [15:0] err_r,       err_nxt;
  logic signed [24:0] prod_r,      prod_nxt;
  logic signed [15:0] corr_r,      corr_nxt;
  logic               pend_bit_r,  pend_bit_nxt;
  logic               pend_lock_r, pend_lock_nxt;
  fdsd_pkg::out_t     out_data_r,  out_data_nxt;

  // Combinational terms.
  logic signed [17:0] half_p, three_half_p, period_s, phase_less_p;
  logic [15:0]        three_p;
  logic [7:0]         zr_inc;
  logic               recentre;
  logic [7:0]         gain_a;
  logic signed [24:0] mul_a, mul_p;
  logic signed [25:0] integ_sum, lim, integ_clamp, pi_sum;
  logic [25:0]        pi_mag;
  logic [17:0]        pi_q;
  logic [23:0]        prod_mag;
  logic [44:0]        recip_prod;
  logic [17:0]        recip_q;
  logic signed [17:0] apply_sum, floor_s, ceil_s, clamp_lo, clamp_hi;
  logic [8:0]         ones_inc;
  logic               final_lock;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loop_mode_r      <= fdsd_pkg::LOOP_MODE_RST;
      clock_centre_r   <= fdsd_pkg::CLOCK_CENTRE_RST;
      clock_floor_r    <= fdsd_pkg::CLOCK_FLOOR_RST;
      clock_ceiling_r  <= fdsd_pkg::CLOCK_CEILING_RST;
      adjust_percent_r <= fdsd_pkg::ADJUST_PERCENT_RST;
      loop_gains_r     <= fdsd_pkg::LOOP_GAINS_RST;
      noise_floor_r    <= fdsd_pkg::NOISE_FLOOR_RST;
      zero_run_limit_r <= fdsd_pkg::ZERO_RUN_LIMIT_RST;
    end else if (cfg_we) begin
      case (fdsd_pkg::cfg_reg_t'(cfg_index))
        fdsd_pkg::REG_LOOP_MODE:      loop_mode_r      <= cfg_data[0];
        fdsd_pkg::REG_CLOCK_CENTRE:   clock_centre_r   <= cfg_data[13:0];
        fdsd_pkg::REG_CLOCK_FLOOR:    clock_floor_r    <= cfg_data[13:0];
        fdsd_pkg::REG_CLOCK_CEILING:  clock_ceiling_r  <= cfg_data[13:0];
        fdsd_pkg::REG_ADJUST_PERCENT: adjust_percent_r <= cfg_data[6:0];
        fdsd_pkg::REG_LOOP_GAINS:     loop_gains_r     <= cfg_data;
        fdsd_pkg::REG_NOISE_FLOOR:    noise_floor_r    <= cfg_data;
        fdsd_pkg::REG_ZERO_RUN_LIMIT: zero_run_limit_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Phase window thresholds against the current cell period.
  assign period_s     = $signed({4'b0, period_r});
  assign half_p       = $signed({5'b0, period_r[13:1]});
  assign three_p      = {2'b0, period_r} + {1'b0, period_r, 1'b0};
  assign three_half_p = $signed({3'b0, three_p[15:1]});
  assign phase_less_p = phase_r - period_s;

  // Zero-run bookkeeping for a zero cell.
  assign zr_inc   = (zero_run_r != 8'hFF) ? zero_run_r + 8'd1 : zero_run_r;
  assign recentre = zr_inc > zero_run_limit_r;

  // First multiply: percent gain, or integral gain in PI mode.
  assign gain_a = loop_mode_r ? loop_gains_r[7:0] : {1'b0, adjust_percent_r};
  assign mul_a  = 25'(err_r * $signed({1'b0, gain_a}));
  assign mul_p  = 25'(err_r * $signed({1'b0, loop_gains_r[15:8]}));

  // Integral update with a clamp at half the centre period in Q.8.
  assign lim         = $signed({5'b0, clock_centre_r, 7'b0});
  assign integ_sum   = 26'(integ_r) + 26'(prod_r);
  assign integ_clamp = (integ_sum > lim) ? lim : ((integ_sum < -lim) ? -lim : integ_sum);

  // PI correction truncated toward zero to whole ns.
  assign pi_sum = 26'(prod_r) + 26'(integ_r);
  assign pi_mag = pi_sum[25] ? 26'(-pi_sum) : 26'(pi_sum);
  assign pi_q   = pi_mag[25:8];

  // Percent correction: magnitude divided by 100 through the reciprocal.
  assign prod_mag   = prod_r[24] ? 24'(-prod_r) : 24'(prod_r);
  assign recip_prod = 45'(prod_mag) * 45'(fdsd_pkg::RECIP_100);
  assign recip_q    = recip_prod[fdsd_pkg::RECIP_SHIFT +: 18];

  // Period correction with floor applied before ceiling.
  assign apply_sum = period_s + 18'(corr_r);
  assign floor_s   = $signed({4'b0, clock_floor_r});
  assign ceil_s    = $signed({4'b0, clock_ceiling_r});
  assign clamp_lo  = (apply_sum < floor_s) ? floor_s : apply_sum;
  assign clamp_hi  = (clamp_lo > ceil_s) ? ceil_s : clamp_lo;

  // Lock update at the end of an item.
  assign ones_inc   = (ones_r < 9'(LockOnes)) ? ones_r + 9'd1 : ones_r;
  assign final_lock = lock_r | (pend_bit_r & (ones_inc >= 9'(LockOnes)));

  // Command decode.
  always_comb begin
    period_nxt    = period_r;
    phase_nxt     = phase_r;
    zero_run_nxt  = zero_run_r;
    ones_nxt      = ones_r;
    lock_nxt      = lock_r;
    integ_nxt     = integ_r;
    err_nxt       = err_r;
    prod_nxt      = prod_r;
    corr_nxt      = corr_r;
    pend_bit_nxt  = pend_bit_r;
    pend_lock_nxt = pend_lock_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    case (cmd.op)
      fdsd_pkg::DP_INDEX: begin
        phase_nxt = '0;
      end
      fdsd_pkg::DP_ADD: begin
        phase_nxt = phase_r + $signed({2'b0, in_data.flux_interval});
      end
      fdsd_pkg::DP_CELL: begin
        if (cmd.emit) begin
          out_data_nxt  = '{cell_bit: pend_bit_r, last_cell: 1'b0,
                            locked: pend_lock_r, overrun: 1'b0};
          out_valid_nxt = 1'b1;
        end
        if (phase_r >= three_half_p) begin
          // Zero cell: no correction, may lose lock and recentre.
          zero_run_nxt  = zr_inc;
          phase_nxt     = phase_less_p;
          pend_bit_nxt  = 1'b0;
          pend_lock_nxt = lock_r;
          if (recentre) begin
            lock_nxt      = 1'b0;
            pend_lock_nxt = 1'b0;
            period_nxt    = clock_centre_r;
            if (loop_mode_r) begin
              integ_nxt = '0;
            end
          end
        end else begin
          // One cell: capture the phase error for the correction steps.
          zero_run_nxt  = '0;
          err_nxt       = 16'(phase_less_p);
          pend_bit_nxt  = 1'b1;
          pend_lock_nxt = lock_r;
        end
      end
      fdsd_pkg::DP_MUL: begin
        prod_nxt = mul_a;
      end
      fdsd_pkg::DP_RECIP: begin
        corr_nxt = prod_r[24] ? -16'(recip_q) : 16'(recip_q);
      end
      fdsd_pkg::DP_INTEG: begin
        integ_nxt = 23'(integ_clamp);
        prod_nxt  = mul_p;
      end
      fdsd_pkg::DP_SUM_PI: begin
        corr_nxt = pi_sum[25] ? -16'(pi_q) : 16'(pi_q);
      end
      fdsd_pkg::DP_APPLY: begin
        period_nxt = clamp_hi[13:0];
      end
      fdsd_pkg::DP_PHASE: begin
        phase_nxt = phase_less_p;
      end
      fdsd_pkg::DP_FINISH: begin
        out_data_nxt  = '{cell_bit: pend_bit_r, last_cell: 1'b1,
                          locked: final_lock, overrun: cmd.overrun};
        out_valid_nxt = 1'b1;
        if (pend_bit_r) begin
          ones_nxt = ones_inc;
          lock_nxt = final_lock;
        end
        if (cmd.overrun) begin
          phase_nxt = '0;
        end
      end
      default: ;
    endcase
  end

  // Loop state and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r    <= fdsd_pkg::CLOCK_CENTRE_RST;
      phase_r     <= '0;
      zero_run_r  <= '0;
      ones_r      <= '0;
      lock_r      <= 1'b0;
      integ_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      period_r    <= period_nxt;
      phase_r     <= phase_nxt;
      zero_run_r  <= zero_run_nxt;
      ones_r      <= ones_nxt;
      lock_r      <= lock_nxt;
      integ_r     <= integ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working values and output payload.
  always_ff @(posedge clk) begin
    err_r       <= err_nxt;
    prod_r      <= prod_nxt;
    corr_r      <= corr_nxt;
    pend_bit_r  <= pend_bit_nxt;
    pend_lock_r <= pend_lock_nxt;
    out_data_r  <= out_data_nxt;
  end

  // Status back to the controller.
  assign status = '{more:      phase_r >= half_p,
                    zero_cell: phase_r >= three_half_p,
                    out_free:  ~out_valid_r | out_ready,
                    pi_mode:   loop_mode_r,
                    is_index:  in_data.opcode == fdsd_pkg::OPC_INDEX,
                    is_short:  in_data.flux_interval < noise_floor_r};

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== sv/fdsd_ctrl.sv =====
// Controller of the flux data separator: sequences one input item through
// its bit cells and the loop correction steps, counting cells per item.
// Depends on fdsd_pkg; drives fdsd_datapath through command and status.
module fdsd_ctrl #(
  parameter int MaxCells = fdsd_pkg::MAX_CELLS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  fdsd_pkg::dp_status_t status,
  output fdsd_pkg::dp_cmd_t    cmd
);

  localparam int CntW = $clog2(MaxCells + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_MUL,
    S_RECIP,
    S_INTEG,
    S_SUM_PI,
    S_APPLY,
    S_PHASE
  } state_t;

  state_t          state_r, state_nxt;
  logic [CntW-1:0] cells_r, cells_nxt;
  logic            pend_r,  pend_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and datapath command.
  always_comb begin
    state_nxt = state_r;
    cells_nxt = cells_r;
    pend_nxt  = pend_r;
    cmd       = '{op: fdsd_pkg::DP_NOP, emit: 1'b0, overrun: 1'b0};
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (status.is_index) begin
            cmd.op = fdsd_pkg::DP_INDEX;
          end else if (!status.is_short) begin
            cmd.op    = fdsd_pkg::DP_ADD;
            cells_nxt = '0;
            pend_nxt  = 1'b0;
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (!status.more) begin
          // Phase window closed: the pending cell, if any, is the last one.
          if (!pend_r) begin
            state_nxt = S_IDLE;
          end else if (status.out_free) begin
            cmd.op    = fdsd_pkg::DP_FINISH;
            pend_nxt  = 1'b0;
            state_nxt = S_IDLE;
          end
        end else if (cells_r == CntW'(MaxCells)) begin
          // Cell limit reached with phase left over.
          if (status.out_free) begin
            cmd.op      = fdsd_pkg::DP_FINISH;
            cmd.overrun = 1'b1;
            pend_nxt    = 1'b0;
            state_nxt   = S_IDLE;
          end
        end else if (!pend_r || status.out_free) begin
          cmd.op    = fdsd_pkg::DP_CELL;
          cmd.emit  = pend_r;
          pend_nxt  = 1'b1;
          cells_nxt = cells_r + 1'b1;
          state_nxt = status.zero_cell ? S_CHECK : S_MUL;
        end
      end
      S_MUL: begin
        cmd.op    = fdsd_pkg::DP_MUL;
        state_nxt = status.pi_mode ? S_INTEG : S_RECIP;
      end
      S_RECIP: begin
        cmd.op    = fdsd_pkg::DP_RECIP;
        state_nxt = S_APPLY;
      end
      S_INTEG: begin
        cmd.op    = fdsd_pkg::DP_INTEG;
        state_nxt = S_SUM_PI;
      end
      S_SUM_PI: begin
        cmd.op    = fdsd_pkg::DP_SUM_PI;
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        cmd.op    = fdsd_pkg::DP_APPLY;
        state_nxt = S_PHASE;
      end
      S_PHASE: begin
        cmd.op    = fdsd_pkg::DP_PHASE;
        state_nxt = S_CHECK;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and cell bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cells_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cells_r <= cells_nxt;
      pend_r  <= pend_nxt;
    end
  end

endmodule

// ===== sv/flux_data_separator_dpll.sv =====
// Flux data separator DPLL: turns flux intervals into decoded bit cells.
// Top level joining fdsd_ctrl and fdsd_datapath; depends on fdsd_pkg.
//
// Input beats carry an opcode and a flux interval in ns. An index pulse clears
// the phase and yields no result; an interval below the noise floor is dropped.
// Every other interval yields zero to MaxCells result beats, one per bit cell,
// the final one marked by last_cell and carrying the lock flag after this
// item's lock update and the overrun flag.
// Sequence: index pulses and noise are handled while idle. A flux item is
// accepted, then a zero cell takes a check step and a one cell a check, multiply,
// reciprocal or integral and PI sum, apply and phase step; a last check closes it.
// The cell loop runs its correction steps through separate controller states.
// Results leave through one output register; a stalled receiver holds the
// loop at the next cell until the register frees, and no beat is lost.
// in_ready is high only while no item is in progress.
// Configuration writes take effect at once; write only while the block idles.
// Reset (synchronous, active low) restores register defaults, sets the cell
// period to the centre value and clears phase, counters, lock and integral.
module flux_data_separator_dpll #(
  parameter int LockOnes = fdsd_pkg::LOCK_ONES_DEF,
  parameter int MaxCells = fdsd_pkg::MAX_CELLS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [fdsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fdsd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  fdsd_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output fdsd_pkg::out_t                  out_data
);

  fdsd_pkg::dp_cmd_t    cmd;
  fdsd_pkg::dp_status_t status;

  // Sequencer.
  fdsd_ctrl #(
    .MaxCells(MaxCells)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .status  (status),
    .cmd     (cmd)
  );

  // Loop arithmetic and output register.
  fdsd_datapath #(
    .LockOnes(LockOnes)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

`ifndef NO_ASSERTIONS
  // An overrun is only ever reported on the final cell of an item.
  a_overrun_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_data.overrun || out_data.last_cell))
    else $error("overrun flagged on a non-final cell");

  // An index pulse leaves the block ready again in the next cycle.
  a_index_quick: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.opcode) |=> in_ready)
    else $error("index pulse did not return to ready");

  // A freshly accepted item cannot produce a result in the very next cycle.
  a_no_instant_out: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !$rose(out_valid))
    else $error("result appeared one cycle after acceptance");
`endif

endmodule
